/* src/bgs_pkg.sv */
// ---------------------------------------------------------------------------
// bgs_pkg
// Shared constants, register indexes and types for the biquad, gain and
// soft saturator unit.
// ---------------------------------------------------------------------------
package bgs_pkg;

  localparam int ChannelsDef = 2;
  localparam int SampleW     = 24;
  localparam int CoefW       = 32;
  localparam int GainW       = 16;
  localparam int StateW      = 48;
  localparam int CfgIdxW     = 3;

  localparam logic [GainW-1:0] UnityGain = 16'd4096;
  localparam logic [23:0]      ThreshQ20 = 24'd838861;

  typedef enum logic [CfgIdxW-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MB0,
    ST_Y,
    ST_MB1,
    ST_MA1,
    ST_MB2,
    ST_MA2,
    ST_GAIN,
    ST_SQ,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

/* src/biquad_gain_soft_saturator_unit.sv */
// ---------------------------------------------------------------------------
// biquad_gain_soft_saturator_unit
// Biquad filter (transposed DF-II), drive gain and soft saturator on a
// stream of channel-tagged Q3.20 samples.
// ---------------------------------------------------------------------------
// One word at a time. A shared shift-add multiplier takes two operand bits
// per cycle, and each multiply step holds the sequencer until its product
// is handed off. The five filter products, the gain product and the square
// of the overshoot run on it in turn, and the soft-clip quotient comes from
// a restoring divider one quotient bit per cycle. Soft clipping adds the
// square and divide steps, and a finished word also waits for the output
// register. The result sits in an output register, and the next word is
// accepted once that register has been loaded.
module biquad_gain_soft_saturator_unit #(
  parameter int CHANNELS = bgs_pkg::ChannelsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [bgs_pkg::SampleW-1:0] in_sample_in,
  input  logic                        in_channel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [bgs_pkg::SampleW-1:0] out_sample_out,
  input  logic                        cfg_we,
  input  logic [bgs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bgs_pkg::CoefW-1:0]   cfg_data
);
  import bgs_pkg::*;

  localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MulW = 64;

  // configuration registers
  logic signed [CoefW-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [GainW-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= 32'sd268435456;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
      gain_r <= UnityGain;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:   b0_r <= cfg_data;
        REG_B1:   b1_r <= cfg_data;
        REG_B2:   b2_r <= cfg_data;
        REG_A1:   a1_r <= cfg_data;
        REG_A2:   a2_r <= cfg_data;
        REG_GAIN: gain_r <= cfg_data[GainW-1:0];
        default: ;
      endcase
    end
  end

  // per-channel filter state
  logic signed [StateW-1:0] s1_r [CHANNELS];
  logic signed [StateW-1:0] s2_r [CHANNELS];

  state_t state_r, state_nxt;
  logic [ChW-1:0] ch_r;
  logic signed [SampleW-1:0] x_r, y_r;
  logic signed [StateW+1:0] acc_r;
  logic signed [47:0] p_r;
  logic neg_r;
  logic [43:0] d_r;
  logic out_valid_r;
  logic signed [SampleW-1:0] out_r;

  // serial multiplier: multiplicand mc_r times multiplier mp_r, 2 bits/cycle
  logic signed [MulW-1:0] mc_r, mp_r, prod_r;
  logic [5:0] mcnt_r;
  logic mbusy_r, mstart;
  logic signed [MulW-1:0] mc_in, mp_in;
  logic [5:0] mcnt_in;

  // divider: quotient of dnum_r / den_r, one bit per cycle
  logic [43:0] quo_r;
  logic [44:0] rem_r;
  logic [47:0] dnum_r;
  logic [44:0] den_r;
  logic [5:0] dcnt_r;

  logic accept;
  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_sample_out = out_r;

  // channel index wraps modulo CHANNELS
  logic [ChW-1:0] ch_in;
  always_comb begin
    if (CHANNELS > 1) ch_in = ChW'(in_channel);
    else ch_in = '0;
  end

  // helpers
  function automatic logic signed [StateW+1:0] sat48(input logic signed [StateW+1:0] v);
    logic signed [StateW+1:0] hi, lo;
    hi = {3'b000, {(StateW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  logic signed [StateW+1:0] prod_sh;
  assign prod_sh = (StateW+2)'(prod_r >>> 8);

  // saturated state update
  logic signed [StateW+1:0] snew;
  assign snew = sat48(acc_r - prod_sh);

  // rounded filter output
  logic signed [StateW+1:0] yr;
  logic signed [SampleW-1:0] ysat;
  always_comb begin
    yr = (acc_r + 50'sd524288) >>> 20;
    if (yr > 50'sd8388607) ysat = 24'sh7FFFFF;
    else if (yr < -50'sd8388608) ysat = 24'sh800000;
    else ysat = yr[SampleW-1:0];
  end

  logic signed [47:0] pg;
  assign pg = (48'(prod_r) + 48'sd2048) >>> 12;
  logic signed [47:0] thr;
  assign thr = 48'(ThreshQ20);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MB0;
      ST_MB0:  if (!mbusy_r && !mstart) state_nxt = ST_Y;
      ST_Y:    state_nxt = ST_MB1;
      ST_MB1:  if (!mbusy_r && !mstart) state_nxt = ST_MA1;
      ST_MA1:  if (!mbusy_r && !mstart) state_nxt = ST_MB2;
      ST_MB2:  if (!mbusy_r && !mstart) state_nxt = ST_MA2;
      ST_MA2:  if (!mbusy_r && !mstart) state_nxt = ST_GAIN;
      ST_GAIN: if (!mbusy_r && !mstart) begin
        if (gain_r > UnityGain && (pg > thr || pg < -thr)) state_nxt = ST_SQ;
        else state_nxt = ST_DONE;
      end
      ST_SQ:   if (!mbusy_r && !mstart) state_nxt = ST_DIV;
      ST_DIV:  if (dcnt_r == 6'd0) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // multiplier launch: start in the first cycle of each multiply state
  logic started_r;
  always_comb begin
    mstart = 1'b0;
    mc_in = '0;
    mp_in = '0;
    mcnt_in = 6'd12;
    if (!started_r) begin
      case (state_r)
        ST_MB0: begin mstart = 1'b1; mc_in = MulW'(b0_r); mp_in = MulW'(x_r); end
        ST_MB1: begin mstart = 1'b1; mc_in = MulW'(b1_r); mp_in = MulW'(x_r); end
        ST_MA1: begin mstart = 1'b1; mc_in = MulW'(a1_r); mp_in = MulW'(y_r); end
        ST_MB2: begin mstart = 1'b1; mc_in = MulW'(b2_r); mp_in = MulW'(x_r); end
        ST_MA2: begin mstart = 1'b1; mc_in = MulW'(a2_r); mp_in = MulW'(y_r); end
        ST_GAIN: begin
          mstart = 1'b1; mc_in = MulW'($signed({1'b0, gain_r})); mp_in = MulW'(y_r);
        end
        ST_SQ: begin
          mstart = 1'b1; mc_in = MulW'(d_r); mp_in = MulW'(d_r); mcnt_in = 6'd22;
        end
        default: ;
      endcase
    end
  end

  // radix-4 signed shift-add step
  logic signed [MulW-1:0] pp;
  always_comb begin
    pp = '0;
    if (mp_r[0]) pp = pp + mc_r;
    if (mp_r[1]) pp = pp + (mc_r <<< 1);
    // top digit of a signed multiplier carries negative weight
    if (mcnt_r == 6'd1 && mp_r[1]) pp = pp - (mc_r <<< 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      started_r <= 1'b0;
    end else begin
      if (state_nxt != state_r) started_r <= 1'b0;
      else if (mstart) started_r <= 1'b1;
      if (mstart) mbusy_r <= 1'b1;
      else if (mbusy_r && mcnt_r == 6'd1) mbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mstart) begin
      mc_r <= mc_in;
      mp_r <= mp_in;
      prod_r <= '0;
      mcnt_r <= mcnt_in;
    end else if (mbusy_r) begin
      prod_r <= prod_r + pp;
      mc_r <= mc_r <<< 2;
      mp_r <= mp_r >>> 2;
      mcnt_r <= mcnt_r - 6'd1;
    end
  end

  // datapath, control part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        s1_r[i] <= '0;
        s2_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_DONE && state_nxt == ST_IDLE) out_valid_r <= 1'b1;
      if (state_r == ST_MA1 && state_nxt == ST_MB2) s1_r[ch_r] <= snew[StateW-1:0];
      if (state_r == ST_MA2 && state_nxt == ST_GAIN) s2_r[ch_r] <= snew[StateW-1:0];
    end
  end

  // datapath, payload part
  logic [44:0] rtry;
  logic signed [47:0] pfin;
  assign rtry = {rem_r[43:0], dnum_r[47]} - den_r;

  always_comb begin
    pfin = p_r;
    if (state_r == ST_DONE && neg_r) pfin = -thr - 48'(quo_r);
    else if (state_r == ST_DONE && d_r != '0) pfin = thr + 48'(quo_r);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_sample_in;
      ch_r <= ch_in;
      d_r <= '0;
      neg_r <= 1'b0;
    end
    case (state_r)
      ST_MB0: if (state_nxt == ST_Y)
        acc_r <= prod_sh + (StateW+2)'(s1_r[ch_r]);
      ST_Y: y_r <= ysat;
      ST_MB1: if (state_nxt == ST_MA1)
        acc_r <= prod_sh + (StateW+2)'(s2_r[ch_r]);
      ST_MB2: if (state_nxt == ST_MA2) acc_r <= prod_sh;
      ST_GAIN: if (!mbusy_r && !mstart) begin
        p_r <= pg;
        // soft clip only above unity gain
        if (gain_r > UnityGain) begin
          if (pg > thr) d_r <= 44'(pg - thr);
          else if (pg < -thr) begin
            d_r <= 44'(-thr - pg);
            neg_r <= 1'b1;
          end
        end
      end
      ST_SQ: if (!mbusy_r && !mstart) begin
        den_r <= 45'(1 << 20) + 45'(prod_r >>> 20);
        dnum_r <= 48'(d_r) << 20;
        rem_r <= '0;
        quo_r <= '0;
        dcnt_r <= 6'd48;
      end
      ST_DIV: if (dcnt_r != 6'd0) begin
        dcnt_r <= dcnt_r - 6'd1;
        dnum_r <= dnum_r << 1;
        if (!rtry[44]) begin
          rem_r <= rtry;
          quo_r <= {quo_r[42:0], 1'b1};
        end else begin
          rem_r <= {rem_r[43:0], dnum_r[47]};
          quo_r <= {quo_r[42:0], 1'b0};
        end
      end
      ST_DONE: if (state_nxt == ST_IDLE) begin
        if (pfin > 48'sd8388607) out_r <= 24'sh7FFFFF;
        else if (pfin < -48'sd8388608) out_r <= 24'sh800000;
        else out_r <= pfin[SampleW-1:0];
      end
      default: ;
    endcase
  end

endmodule

/* src/bgs_checker.sv */
// ---------------------------------------------------------------------------
// bgs_port_checker
// Port-level checks for the biquad, gain and soft saturator unit.
// ---------------------------------------------------------------------------
module bgs_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_sample_out
);
  // a result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("result word changed while stalled");

  // no new word accepted in the cycle after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // no result right after acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");
endmodule

bind biquad_gain_soft_saturator_unit bgs_port_checker u_bgs_port_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_sample_out(out_sample_out)
);

/* bench/bgs_checker.sv */
// ---------------------------------------------------------------------------
// bgs_checker
// Watches the sample and result channels of the biquad, gain and soft
// saturator unit, computes the expected output of each accepted word and
// compares it with the word that comes out.
// ---------------------------------------------------------------------------
module bgs_checker
  import bgs_pkg::*;
#(
  parameter int CHANNELS = ChannelsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [SampleW-1:0] in_sample_in,
  input  logic                      in_channel,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [SampleW-1:0] out_sample_out,
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CoefW-1:0]          cfg_data,
  output int                        fail_count,
  output int                        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of registers and per-channel filter memory
  longint b0_q, b1_q, b2_q, a1_q, a2_q;
  longint gain_q;
  longint z1_q [CHANNELS];
  longint z2_q [CHANNELS];
  logic signed [SampleW-1:0] expected_samples [$];

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp_bits(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint knee_offset(longint d);
    longint den;
    den = (64'sd1 <<< 20) + ((d * d) >>> 20);
    return (d <<< 20) / den;
  endfunction

  // Run one sample through filter, gain and soft clip; update channel memory
  function automatic logic signed [SampleW-1:0] shape_sample(
    logic signed [SampleW-1:0] smp, int ch);
    longint x, acc, y, p, thr;
    x = smp;
    thr = ThreshQ20;
    acc = floor_shift(b0_q * x, 8) + z1_q[ch];
    y = clamp_bits(floor_shift(acc + (64'sd1 <<< 19), 20), SampleW);
    z1_q[ch] = clamp_bits(floor_shift(b1_q * x, 8) - floor_shift(a1_q * y, 8)
                          + z2_q[ch], StateW);
    z2_q[ch] = clamp_bits(floor_shift(b2_q * x, 8) - floor_shift(a2_q * y, 8),
                          StateW);
    p = floor_shift(y * gain_q + 2048, 12);
    if (gain_q > longint'(UnityGain)) begin
      if (p > thr) p = thr + knee_offset(p - thr);
      else if (p < -thr) p = -thr - knee_offset(-thr - p);
    end
    return SampleW'(clamp_bits(p, SampleW));
  endfunction

  always @(posedge clk) begin
    logic signed [SampleW-1:0] want;
    if (!rst_n) begin
      b0_q <= 268435456; b1_q <= 0; b2_q <= 0; a1_q <= 0; a2_q <= 0;
      gain_q <= UnityGain;
      for (int i = 0; i < CHANNELS; i++) begin
        z1_q[i] <= 0;
        z2_q[i] <= 0;
      end
      expected_samples.delete();
      fail_count <= 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_B0:   b0_q <= longint'($signed(cfg_data));
          REG_B1:   b1_q <= longint'($signed(cfg_data));
          REG_B2:   b2_q <= longint'($signed(cfg_data));
          REG_A1:   a1_q <= longint'($signed(cfg_data));
          REG_A2:   a2_q <= longint'($signed(cfg_data));
          REG_GAIN: gain_q <= longint'(cfg_data[GainW-1:0]);
          default: ;
        endcase
      end
      // Predict on each accepted input word
      if (in_valid && in_ready)
        expected_samples.push_back(shape_sample(in_sample_in,
                                   int'(in_channel) % CHANNELS));
      // Compare each accepted output word
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected word, actual %0d", $time, out_sample_out);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (want !== out_sample_out) begin
            $display("%0t: sample_out expected %0d actual %0d", $time, want,
                     out_sample_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = expected_samples.size();
endmodule

/* bench/tb_biquad_gain_soft_saturator_unit.sv */
// ---------------------------------------------------------------------------
// tb_biquad_gain_soft_saturator_unit
// Drives directed and random samples through several coefficient and gain
// settings with random idling on both sides; a checker module predicts.
// ---------------------------------------------------------------------------
module tb_biquad_gain_soft_saturator_unit;
  import bgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandWords = 1950;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SampleW-1:0] in_sample_in = '0;
  logic in_channel = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SampleW-1:0] out_sample_out;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoefW-1:0] cfg_data = '0;
  int fail_count;
  int pending_count;
  int rx_wait = 0;
  bit stim_done = 1'b0;
  bit stall_req = 1'b0;
  bit hold_off = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  biquad_gain_soft_saturator_unit dut (.*);

  bgs_checker chk (.*);

  task automatic write_reg(cfg_reg_t idx, logic [CoefW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(logic signed [SampleW-1:0] smp, logic ch);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= smp;
    in_channel <= ch;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every expected word, then let the unit settle
  task automatic drain_unit();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic load_setting(int b0, int b1, int b2, int a1, int a2, int g);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_GAIN, g);
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return SampleW'($urandom_range(0, 2000000)) - 24'sd1000000;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Receiver: random wait per word, one long hold-off when asked
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= $urandom_range(0, 9);
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      gap = $urandom_range(0, 9);
      rx_wait <= gap;
      out_ready <= (gap == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: unity pass-through, edge samples on both channels
    send_word(24'sh7FFFFF, 1'b0);
    send_word(24'sh800000, 1'b1);
    send_word(24'sh000000, 1'b0);
    send_word(24'sh000001, 1'b1);
    send_word(24'shFFFFFF, 1'b0);
    drain_unit();

    // Extreme coefficients and maximum gain drive every overflow path
    load_setting(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h7FFFFFFF, 16'hFFFF);
    repeat (6) send_word(24'sh7FFFFF, 1'b0);
    repeat (6) send_word(24'sh800000, 1'b1);
    drain_unit();

    // Zero gain, then gain just above unity around the knee
    load_setting(268435456, 0, 0, 0, 0, 0);
    send_word(24'sh400000, 1'b0);
    drain_unit();
    write_reg(REG_GAIN, 4097);
    send_word(24'sd838861, 1'b0);
    send_word(24'sd838862, 1'b1);
    send_word(-24'sd838862, 1'b0);
    send_word(24'sh7FFFFF, 1'b1);
    drain_unit();

    // Random phases over several filter and gain settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_setting(268435456, 0, 0, 0, 0, 4096);
        1: load_setting(289000000, -536000000, 250000000, -536000000,
                        270000000, 8192);
        2: load_setting($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(0, 65535));
        3: load_setting(134217728, 134217728, 0, -134217728, 0, 40960);
        4: load_setting(268435456, 0, 0, 0, 0, 4096);
        default: load_setting($urandom, $urandom, $urandom, 0, 0,
                              $urandom_range(4097, 40960));
      endcase
      for (int n = 0; n < RandWords / 6; n++) begin
        if (ph == 1 && n == 10) stall_req <= 1'b1;
        if (ph == 4 && n < 60) send_word(rand_sample(), n[0]);
        else if (ph == 4) begin
          // No gap: back-to-back words
          in_valid <= 1'b1;
          in_sample_in <= rand_sample();
          in_channel <= 1'($urandom_range(0, 1));
          do @(posedge clk); while (!in_ready);
        end else send_word(rand_sample(), 1'($urandom_range(0, 1)));
      end
      drain_unit();
    end
    stim_done <= 1'b1;
  end

  // Long receiver stall, counted in cycles, while the sender keeps offering
  initial begin
    wait (stall_req);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    if (fail_count == 0)
      $display("biquad_gain_soft_saturator_unit: match");
    else
      $display("biquad_gain_soft_saturator_unit: mismatch");
    $finish;
  end

  initial begin
    #10000000;
    $display("biquad_gain_soft_saturator_unit: mismatch");
    $finish;
  end
endmodule
